// ===== hdl/acc_pkg.sv =====
// Package with shared types, codes and helper functions of the alarm clock controller.
`timescale 1ns / 1ps

package acc_pkg;

   // Item kinds on the request channel.
   localparam logic [1:0] FUNC_TICK    = 2'd0;
   localparam logic [1:0] FUNC_BUTTON  = 2'd1;
   localparam logic [1:0] FUNC_ENCODER = 2'd2;

   // Button indexes.
   localparam logic [2:0] BTN_MODE_12_24   = 3'd0;
   localparam logic [2:0] BTN_CLOCK_LOCK   = 3'd1;
   localparam logic [2:0] BTN_CLOCK_HOUR5  = 3'd2;
   localparam logic [2:0] BTN_CLOCK_MIN10  = 3'd3;
   localparam logic [2:0] BTN_ALARM_LOCK   = 3'd4;
   localparam logic [2:0] BTN_ALARM_STOP   = 3'd5;
   localparam logic [2:0] BTN_ALARM_HOUR1  = 3'd6;
   localparam logic [2:0] BTN_ALARM_MIN1   = 3'd7;

   // Reset values of the time of day, the tick rate and the colon.
   localparam logic [7:0] RESET_TICKS_PER_SECOND = 8'd128;
   localparam logic [5:0] RESET_MINUTES          = 6'd50;
   localparam logic [4:0] RESET_HOURS            = 5'd13;
   localparam logic [7:0] RESET_COLON            = 8'hFF;

   // Bar graph patterns and the colon blink mask.
   localparam logic [7:0] BAR_CLOCK_EDIT = 8'h01;
   localparam logic [7:0] BAR_ALARM_EDIT = 8'h02;
   localparam logic [7:0] BAR_ARMED      = 8'hC0;
   localparam logic [7:0] COLON_BLINK_MASK = 8'h03;

   localparam logic [7:0] SEG_BLANK = 8'hFF;

   typedef struct packed {
      logic [1:0] func;
      logic [2:0] button;
      logic       turn_clockwise;
   } req_type;

   typedef struct packed {
      logic [7:0] minute_ones_segments;
      logic [7:0] minute_tens_segments;
      logic [7:0] hour_ones_segments;
      logic [7:0] hour_tens_segments;
      logic [7:0] colon_segments;
      logic [7:0] bar_pattern;
      logic       ringing;
      logic       armed;
      logic       setting_clock;
      logic       setting_alarm;
   } rsp_type;

   // State after an item, as the display formatter needs it.
   typedef struct packed {
      logic [4:0] shown_hour;
      logic [5:0] shown_minute;
      logic       twelve_hour_mode;
      logic [7:0] colon;
      logic [7:0] bar;
      logic       ringing;
      logic       armed;
      logic       setting_clock;
      logic       setting_alarm;
   } view_type;

   // Active-low seven-segment code of one decimal digit.
   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] code;
      unique case (digit)
         4'd0:    code = 8'b11000000;
         4'd1:    code = 8'b11111001;
         4'd2:    code = 8'b10100100;
         4'd3:    code = 8'b10110000;
         4'd4:    code = 8'b10011001;
         4'd5:    code = 8'b10010010;
         4'd6:    code = 8'b10000010;
         4'd7:    code = 8'b11011000;
         4'd8:    code = 8'b10000000;
         4'd9:    code = 8'b10010000;
         default: code = SEG_BLANK;
      endcase
      return code;
   endfunction

   // Tens digit of a value below 64: multiply by 26 and keep the top bits.
   function automatic logic [2:0] tens_of(input logic [5:0] value);
      logic [10:0] product;
      product = {1'b0, value, 4'b0000} + {2'b00, value, 3'b000} + {4'b0000, value, 1'b0};
      return product[10:8];
   endfunction

endpackage

// ===== hdl/alarm_clock_controller_top.sv =====
// Top level of the alarm clock controller with its result register.
`timescale 1ns / 1ps

// Alarm clock core. Every request (timer tick, button press or encoder step)
// is applied in the cycle it is transferred and gives exactly one response
// in the following cycle: one request per cycle, limited only by the single
// result register. A new request is taken whenever the result register is
// empty or its response is transferred in the same cycle. The tick rate is
// to be written via csr_write_enable and csr_write_data while the block is
// idle (not enforced by the block); a value of 0 counts 256 ticks per second.
module alarm_clock_controller_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  acc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output acc_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [7:0]       csr_write_data
);
   import acc_pkg::*;

   logic     req_fire;
   view_type view;
   rsp_type  result;
   rsp_type  rsp_ff;
   logic     rsp_valid_ff, rsp_valid_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   acc_state u_state (
      .clock            (clock),
      .reset            (reset),
      .req_fire         (req_fire),
      .req_item         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .view             (view)
   );

   acc_display u_display (
      .view   (view),
      .result (result)
   );

   // Result register: loaded on every request transfer.
   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // An empty result register never stalls the request side.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

   // Every request transfer yields a response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
                    req_valid && req_ready |=> rsp_valid)
      else $error("request transfer gave no response");

   // Clock and alarm editing exclude each other.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid |-> !(rsp_data.setting_clock && rsp_data.setting_alarm))
      else $error("clock and alarm edited at once");

endmodule

// ===== hdl/acc_state.sv =====
// Time of day, alarm and edit state, updated once for every accepted request.
`timescale 1ns / 1ps

module acc_state (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_fire,
   input  acc_pkg::req_type req_item,
   input  logic             csr_write_enable,
   input  logic [7:0]       csr_write_data,
   output acc_pkg::view_type view
);
   import acc_pkg::*;

   logic [7:0] tps_ff, tps_in;
   logic [7:0] tick_count_ff, tick_count_in;
   logic [5:0] seconds_ff, seconds_in;
   logic [5:0] minutes_ff, minutes_in;
   logic [4:0] hours_ff, hours_in;
   logic [7:0] colon_ff, colon_in;
   logic       twelve_ff, twelve_in;
   logic       clock_unlocked_ff, clock_unlocked_in;
   logic       alarm_unlocked_ff, alarm_unlocked_in;
   logic [4:0] edit_clock_hour_ff, edit_clock_hour_in;
   logic [5:0] edit_clock_minute_ff, edit_clock_minute_in;
   logic [4:0] edit_alarm_hour_ff, edit_alarm_hour_in;
   logic [5:0] edit_alarm_minute_ff, edit_alarm_minute_in;
   logic [4:0] alarm_hour_ff, alarm_hour_in;
   logic [5:0] alarm_minute_ff, alarm_minute_in;
   logic       armed_ff, armed_in;
   logic       ringing_ff, ringing_in;
   logic [7:0] bar_ff, bar_in;

   logic [7:0] tick_sum;
   logic [5:0] hour_plus5;
   logic [6:0] minute_plus10;

   assign tick_sum      = tick_count_ff + 8'd1;
   assign hour_plus5    = {1'b0, edit_clock_hour_ff} + 6'd5;
   assign minute_plus10 = {1'b0, edit_clock_minute_ff} + 7'd10;

   // Next state for the item being transferred.
   always_comb begin
      tps_in               = csr_write_enable ? csr_write_data : tps_ff;
      tick_count_in        = tick_count_ff;
      seconds_in           = seconds_ff;
      minutes_in           = minutes_ff;
      hours_in             = hours_ff;
      colon_in             = colon_ff;
      twelve_in            = twelve_ff;
      clock_unlocked_in    = clock_unlocked_ff;
      alarm_unlocked_in    = alarm_unlocked_ff;
      edit_clock_hour_in   = edit_clock_hour_ff;
      edit_clock_minute_in = edit_clock_minute_ff;
      edit_alarm_hour_in   = edit_alarm_hour_ff;
      edit_alarm_minute_in = edit_alarm_minute_ff;
      alarm_hour_in        = alarm_hour_ff;
      alarm_minute_in      = alarm_minute_ff;
      armed_in             = armed_ff;
      ringing_in           = ringing_ff;
      bar_in               = bar_ff;

      if (req_fire) begin
         unique case (req_item.func)
            FUNC_TICK: begin
               tick_count_in = tick_sum;
               if (tick_sum == tps_ff) begin
                  tick_count_in = 8'd0;
                  // Advance one second with carries into minutes and hours.
                  if (seconds_ff == 6'd59) begin
                     seconds_in = 6'd0;
                     if (minutes_ff == 6'd59) begin
                        minutes_in = 6'd0;
                        hours_in   = (hours_ff == 5'd23) ? 5'd0 : hours_ff + 5'd1;
                     end else begin
                        minutes_in = minutes_ff + 6'd1;
                     end
                  end else begin
                     seconds_in = seconds_ff + 6'd1;
                  end
                  colon_in = colon_ff ^ COLON_BLINK_MASK;
                  // Alarm match on the new time.
                  if (hours_in == alarm_hour_ff && minutes_in == alarm_minute_ff &&
                      seconds_in == 6'd0) begin
                     armed_in   = 1'b0;
                     ringing_in = 1'b1;
                  end
                  // Bar graph update.
                  priority if (clock_unlocked_ff) begin
                     bar_in = bar_ff | BAR_CLOCK_EDIT;
                  end else if (alarm_unlocked_ff) begin
                     bar_in = BAR_ALARM_EDIT;
                  end else if (armed_in) begin
                     bar_in = BAR_ARMED;
                  end else if (ringing_in) begin
                     bar_in = (bar_ff == 8'd0) ? 8'd1 : {bar_ff[6:0], 1'b0};
                  end else begin
                     bar_in = 8'd0;
                  end
               end
            end
            FUNC_BUTTON: begin
               unique case (req_item.button)
                  BTN_MODE_12_24: twelve_in = ~twelve_ff;
                  BTN_CLOCK_LOCK: begin
                     if (!alarm_unlocked_ff) begin
                        clock_unlocked_in = ~clock_unlocked_ff;
                        if (!clock_unlocked_ff) begin
                           edit_clock_hour_in   = hours_ff;
                           edit_clock_minute_in = minutes_ff;
                        end else begin
                           hours_in   = edit_clock_hour_ff;
                           minutes_in = edit_clock_minute_ff;
                        end
                     end
                  end
                  BTN_CLOCK_HOUR5: begin
                     if (clock_unlocked_ff) begin
                        edit_clock_hour_in = (hour_plus5 >= 6'd24) ?
                           5'(hour_plus5 - 6'd24) : hour_plus5[4:0];
                     end
                  end
                  BTN_CLOCK_MIN10: begin
                     if (clock_unlocked_ff) begin
                        edit_clock_minute_in = (minute_plus10 >= 7'd60) ?
                           6'(minute_plus10 - 7'd60) : minute_plus10[5:0];
                     end
                  end
                  BTN_ALARM_LOCK: begin
                     if (!clock_unlocked_ff) begin
                        alarm_unlocked_in = ~alarm_unlocked_ff;
                        if (!alarm_unlocked_ff) begin
                           edit_alarm_hour_in   = hours_ff;
                           edit_alarm_minute_in = minutes_ff;
                        end else begin
                           alarm_hour_in   = edit_alarm_hour_ff;
                           alarm_minute_in = edit_alarm_minute_ff;
                           armed_in        = 1'b1;
                        end
                     end
                  end
                  BTN_ALARM_STOP: ringing_in = 1'b0;
                  BTN_ALARM_HOUR1: begin
                     if (alarm_unlocked_ff) begin
                        edit_alarm_hour_in = (edit_alarm_hour_ff == 5'd23) ?
                           5'd0 : edit_alarm_hour_ff + 5'd1;
                     end
                  end
                  BTN_ALARM_MIN1: begin
                     if (alarm_unlocked_ff) begin
                        edit_alarm_minute_in = (edit_alarm_minute_ff == 6'd59) ?
                           6'd0 : edit_alarm_minute_ff + 6'd1;
                     end
                  end
               endcase
            end
            FUNC_ENCODER: begin
               // One minute up or down on the edited clock time.
               if (clock_unlocked_ff) begin
                  if (req_item.turn_clockwise) begin
                     if (edit_clock_minute_ff == 6'd59) begin
                        edit_clock_minute_in = 6'd0;
                        edit_clock_hour_in   = (edit_clock_hour_ff == 5'd23) ?
                           5'd0 : edit_clock_hour_ff + 5'd1;
                     end else begin
                        edit_clock_minute_in = edit_clock_minute_ff + 6'd1;
                     end
                  end else begin
                     if (edit_clock_minute_ff == 6'd0) begin
                        edit_clock_minute_in = 6'd59;
                        edit_clock_hour_in   = (edit_clock_hour_ff == 5'd0) ?
                           5'd23 : edit_clock_hour_ff - 5'd1;
                     end else begin
                        edit_clock_minute_in = edit_clock_minute_ff - 6'd1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff               <= RESET_TICKS_PER_SECOND;
         tick_count_ff        <= 8'd0;
         seconds_ff           <= 6'd0;
         minutes_ff           <= RESET_MINUTES;
         hours_ff             <= RESET_HOURS;
         colon_ff             <= RESET_COLON;
         twelve_ff            <= 1'b0;
         clock_unlocked_ff    <= 1'b0;
         alarm_unlocked_ff    <= 1'b0;
         edit_clock_hour_ff   <= 5'd0;
         edit_clock_minute_ff <= 6'd0;
         edit_alarm_hour_ff   <= 5'd0;
         edit_alarm_minute_ff <= 6'd0;
         alarm_hour_ff        <= 5'd0;
         alarm_minute_ff      <= 6'd0;
         armed_ff             <= 1'b0;
         ringing_ff           <= 1'b0;
         bar_ff               <= 8'd0;
      end else begin
         tps_ff               <= tps_in;
         tick_count_ff        <= tick_count_in;
         seconds_ff           <= seconds_in;
         minutes_ff           <= minutes_in;
         hours_ff             <= hours_in;
         colon_ff             <= colon_in;
         twelve_ff            <= twelve_in;
         clock_unlocked_ff    <= clock_unlocked_in;
         alarm_unlocked_ff    <= alarm_unlocked_in;
         edit_clock_hour_ff   <= edit_clock_hour_in;
         edit_clock_minute_ff <= edit_clock_minute_in;
         edit_alarm_hour_ff   <= edit_alarm_hour_in;
         edit_alarm_minute_ff <= edit_alarm_minute_in;
         alarm_hour_ff        <= alarm_hour_in;
         alarm_minute_ff      <= alarm_minute_in;
         armed_ff             <= armed_in;
         ringing_ff           <= ringing_in;
         bar_ff               <= bar_in;
      end
   end

   // The edited time is shown while unlocked, else the running clock.
   always_comb begin
      priority if (clock_unlocked_in) begin
         view.shown_hour   = edit_clock_hour_in;
         view.shown_minute = edit_clock_minute_in;
      end else if (alarm_unlocked_in) begin
         view.shown_hour   = edit_alarm_hour_in;
         view.shown_minute = edit_alarm_minute_in;
      end else begin
         view.shown_hour   = hours_in;
         view.shown_minute = minutes_in;
      end
      view.twelve_hour_mode = twelve_in;
      view.colon            = colon_in;
      view.bar              = bar_in;
      view.ringing          = ringing_in;
      view.armed            = armed_in;
      view.setting_clock    = clock_unlocked_in;
      view.setting_alarm    = alarm_unlocked_in;
   end

endmodule

// ===== hdl/acc_display.sv =====
// Formats the shown time into seven-segment digits and packs the result.
`timescale 1ns / 1ps

module acc_display (
   input  acc_pkg::view_type view,
   output acc_pkg::rsp_type  result
);
   import acc_pkg::*;

   logic [4:0] hour_disp;
   logic [2:0] hour_tens;
   logic [2:0] minute_tens;
   logic [5:0] hour_ones_full;
   logic [5:0] minute_ones_full;

   // Hours 13 to 23 show as 1 to 11 in 12-hour mode.
   assign hour_disp = (view.twelve_hour_mode && view.shown_hour >= 5'd13) ?
                      view.shown_hour - 5'd12 : view.shown_hour;

   // Split both values into decimal digits.
   assign hour_tens        = tens_of({1'b0, hour_disp});
   assign minute_tens      = tens_of(view.shown_minute);
   assign hour_ones_full   = {1'b0, hour_disp} - ({3'b000, hour_tens} * 6'd10);
   assign minute_ones_full = view.shown_minute - ({3'b000, minute_tens} * 6'd10);

   always_comb begin
      result.minute_ones_segments = seg_code(minute_ones_full[3:0]);
      result.minute_tens_segments = seg_code({1'b0, minute_tens});
      result.hour_ones_segments   = seg_code(hour_ones_full[3:0]);
      result.hour_tens_segments   = seg_code({1'b0, hour_tens});
      result.colon_segments       = view.colon;
      result.bar_pattern          = view.bar;
      result.ringing              = view.ringing;
      result.armed                = view.armed;
      result.setting_clock        = view.setting_clock;
      result.setting_alarm        = view.setting_alarm;
   end

endmodule
